/* src/pps_pkg.sv */
package pps_pkg;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] burst;
    } pps_req_t;

    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_index;
        logic        finished;
        logic [31:0] completion_time;
        logic [31:0] waiting_time;
        logic [31:0] turnaround_time;
        logic        all_done;
    } pps_rsp_t;

    // One process table entry as stored in the RAM
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } pps_entry_t;

    localparam int ENTRY_W = $bits(pps_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_EMIT
    } pps_state_t;

endpackage

/* src/pps_ram.sv */
module pps_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler over a table of MAX_PROCS processes.
// Request channel (req_valid / req_stall / req): action LOAD appends a
// process (prio, arrival, burst) to the next free slot, ignored when the
// table is full; action TICK runs the ready process of highest priority
// (lowest slot on a tie) for one unit and advances time by one.
// A load gives no response; loads can come every cycle while no tick runs.
// A tick reads the loaded slots one per cycle from the table RAM in SCAN,
// then passes DRAIN and UPDATE; in EMIT its response is registered, and
// the next request is taken the cycle after. Empty tables skip to UPDATE.
// Response channel (rsp_valid / rsp_stall / rsp): one response per tick.
// While the receiver stalls, the response holds; loads are still taken,
// and a following tick finishes its scan and then waits for the register.
// Reset clears the counts and time; table slots are written by loads and
// only slots below the load count are ever read, so no clearing pass runs.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pps_pkg::pps_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pps_pkg::pps_rsp_t rsp
);

    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    pps_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  loaded_count_reg, loaded_count_next;
    logic [CNT_W-1:0]  done_count_reg, done_count_next;
    logic [31:0]       now_reg, now_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    pps_entry_t        best_reg, best_next;
    logic              fin_reg, fin_next;
    logic [31:0]       comp_reg, comp_next;
    logic [31:0]       turn_reg, turn_next;
    logic              rsp_valid_reg, rsp_valid_next;
    pps_rsp_t          rsp_reg, rsp_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    pps_entry_t        ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    pps_entry_t        rd_entry;

    logic              req_take;
    logic              rsp_free;
    logic              last_addr;
    logic              eligible;
    logic [31:0]       now_inc;
    logic [31:0]       wait_time;

    pps_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_PROCS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign last_addr = (CNT_W'(addr_reg) + CNT_W'(1)) == loaded_count_reg;
    assign eligible  = (32'(rd_entry.arrival) <= now_reg) && (rd_entry.remaining != 16'd0);
    assign now_inc   = (now_reg == 32'hFFFF_FFFF) ? now_reg : now_reg + 32'd1;
    assign wait_time = (turn_reg >= 32'(best_reg.burst)) ? turn_reg - 32'(best_reg.burst)
                                                         : 32'd0;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take && req.action == ACT_TICK)
                begin
                    state_next = (loaded_count_reg == '0) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake and table write controls
    always_comb
    begin
        req_stall = (state_reg != ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = loaded_count_reg[IDX_W-1:0];
        ram_wdata = '{prio: req.prio, arrival: req.arrival, burst: req.burst,
                      remaining: req.burst};
        case (state_reg)
            ST_IDLE:
            begin
                ram_we = req_take && req.action == ACT_LOAD
                         && loaded_count_reg != CNT_W'(MAX_PROCS);
            end
            ST_UPDATE:
            begin
                ram_we    = found_reg;
                ram_waddr = best_idx_reg;
                ram_wdata = best_reg;
                ram_wdata.remaining = best_reg.remaining - 16'd1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        loaded_count_next = loaded_count_reg;
        done_count_next   = done_count_reg;
        now_next          = now_reg;
        addr_next         = addr_reg;
        rd_pend_next      = 1'b0;
        rd_idx_next       = addr_reg;
        found_next        = found_reg;
        best_idx_next     = best_idx_reg;
        best_next         = best_reg;
        fin_next          = fin_reg;
        comp_next         = comp_reg;
        turn_next         = turn_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        rsp_next          = rsp_reg;

        // Compare the entry read in the previous cycle
        if (rd_pend_reg && eligible && (!found_reg || rd_entry.prio > best_reg.prio))
        begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_next     = rd_entry;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take && req.action == ACT_LOAD
                    && loaded_count_reg != CNT_W'(MAX_PROCS))
                begin
                    loaded_count_next = loaded_count_reg + CNT_W'(1);
                    if (req.burst == 16'd0)
                    begin
                        done_count_next = done_count_reg + CNT_W'(1);
                    end
                end
                if (req_take && req.action == ACT_TICK)
                begin
                    found_next = 1'b0;
                    addr_next  = '0;
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = 1'b1;
                if (!last_addr)
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_UPDATE:
            begin
                fin_next  = found_reg && best_reg.remaining == 16'd1;
                comp_next = now_inc;
                turn_next = now_inc - 32'(best_reg.arrival);
                now_next  = now_inc;
                if (found_reg && best_reg.remaining == 16'd1)
                begin
                    done_count_next = done_count_reg + CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.ran_valid        = found_reg;
                    rsp_next.ran_index        = found_reg ? 4'(best_idx_reg) : 4'd0;
                    rsp_next.finished         = fin_reg;
                    rsp_next.completion_time  = fin_reg ? comp_reg : 32'd0;
                    rsp_next.waiting_time     = fin_reg ? wait_time : 32'd0;
                    rsp_next.turnaround_time  = fin_reg ? turn_reg : 32'd0;
                    rsp_next.all_done         = (done_count_reg == loaded_count_reg);
                end
            end
            default:
            begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            loaded_count_reg <= '0;
            done_count_reg   <= '0;
            now_reg          <= '0;
            addr_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            found_reg        <= 1'b0;
            fin_reg          <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            done_count_reg   <= done_count_next;
            now_reg          <= now_next;
            addr_reg         <= addr_next;
            rd_pend_reg      <= rd_pend_next;
            found_reg        <= found_next;
            fin_reg          <= fin_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        comp_reg     <= comp_next;
        turn_reg     <= turn_next;
        rsp_reg      <= rsp_next;
    end

    a_done_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        done_count_reg <= loaded_count_reg)
        else $error("done count exceeds load count");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_count_reg <= CNT_W'(MAX_PROCS))
        else $error("load count exceeds table size");

    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req.action == ACT_TICK |=> req_stall)
        else $error("request taken during a tick");

    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_reg.finished || rsp_reg.ran_valid))
        else $error("finished without a process run");

    a_write_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE && ram_we |-> found_reg && best_reg.remaining != 16'd0)
        else $error("write back of an entry with no work left");

endmodule
